>>> rtl/nidr_pkg.sv
// ----------------------------------------------------------------------------
// nidr_pkg
// Shared types and constants for the name-to-id registry table.
// ----------------------------------------------------------------------------
package nidr_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int KEY_W          = 64;
    localparam int ID_W           = 8;

    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    // server's own name, first byte lowest, first eight bytes only
    localparam logic [KEY_W-1:0] SERVER_KEY = 64'h7265_735F_656D_616E;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;         // capture request, clear scan state
        logic step;         // register: free id match, track free slot
        logic inc_idx;
        logic write_id;     // overwrite id of the matching entry
        logic alloc;        // write name and id into the last free slot
        logic set_res;
        logic res_success;
        logic res_with_id;
        logic publish;      // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic key_zero;
        logic op_reg;
        logic hit;
        logic last;
        logic have_free;
    } t_stat;

    // server key truncated to the configured name length
    function automatic logic [KEY_W-1:0] server_key(input int nbytes);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < nbytes) begin
                k[8*b +: 8] = SERVER_KEY[8*b +: 8];
            end
        end
        return k;
    endfunction

endpackage

>>> rtl/nidr_ctrl.sv
// ----------------------------------------------------------------------------
// nidr_ctrl
// Sequencer for the registry: accept, per-entry scan, allocation, reply.
// ----------------------------------------------------------------------------
module nidr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  nidr_pkg::t_stat i_stat,
    output nidr_pkg::t_cmd  o_cmd
);
    import nidr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.key_zero) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.set_res     = 1'b1;
                    o_cmd.res_success = 1'b1;
                    o_cmd.res_with_id = !i_stat.op_reg;
                    o_cmd.write_id    = i_stat.op_reg;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.step = i_stat.op_reg;
                    if (i_stat.last) begin
                        if (i_stat.op_reg) begin
                            n_state = S_ALLOC;
                        end else begin
                            o_cmd.set_res = 1'b1;
                            n_state       = S_DONE;
                        end
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                o_cmd.alloc       = 1'b1;
                o_cmd.set_res     = 1'b1;
                o_cmd.res_success = i_stat.have_free;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/nidr_dp.sv
// ----------------------------------------------------------------------------
// nidr_dp
// Registry storage, scan pointer, compare logic and output payload register.
// ----------------------------------------------------------------------------
module nidr_dp #(
    parameter int ENTRIES    = nidr_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = nidr_pkg::NAME_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_operation,
    input  logic [nidr_pkg::KEY_W-1:0] i_name_key,
    input  logic [nidr_pkg::ID_W-1:0]  i_task_id,
    input  nidr_pkg::t_cmd           i_cmd,
    output nidr_pkg::t_stat          o_stat,
    output logic                     o_success,
    output logic [nidr_pkg::ID_W-1:0]  o_found_id
);
    import nidr_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [KEY_W-1:0] SRV_KEY = server_key(NAME_BYTES);

    logic [KEY_W-1:0] r_names [ENTRIES];
    logic [ID_W-1:0]  r_ids   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [ID_W-1:0]  r_tid;
    logic [IW-1:0]    r_idx;
    logic             r_have_free;
    logic [IW-1:0]    r_free_idx;
    logic             r_res_success;
    logic [ID_W-1:0]  r_res_id;

    logic [KEY_W-1:0] n_key;
    logic [KEY_W-1:0] rd_name;
    logic [ID_W-1:0]  rd_id;
    logic             rd_valid;
    logic             hit;
    logic             id_match;

    // canonical key: keep bytes up to the first zero byte, within the name length
    always_comb begin
        logic alive;
        alive = 1'b1;
        n_key = '0;
        for (int b = 0; b < 8; b++) begin
            alive = alive && (b < NAME_BYTES) && (i_name_key[8*b +: 8] != 8'h00);
            if (alive) begin
                n_key[8*b +: 8] = i_name_key[8*b +: 8];
            end
        end
    end

    assign rd_name  = r_names[r_idx];
    assign rd_id    = r_ids[r_idx];
    assign rd_valid = r_valid[r_idx];
    assign hit      = rd_valid && (rd_name == r_key);
    assign id_match = rd_valid && (rd_id == r_tid) && !hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= n_key;
            r_tid <= i_task_id;
        end
        if (i_cmd.set_res) begin
            r_res_success <= i_cmd.res_success;
            r_res_id      <= i_cmd.res_with_id ? rd_id : '0;
        end
        if (i_cmd.publish) begin
            o_success  <= r_res_success;
            o_found_id <= r_res_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
        end else if (i_cmd.load) begin
            r_idx       <= '0;
            r_have_free <= 1'b0;
        end else begin
            if (i_cmd.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            // a slot freed in this step counts as free for the rest of the scan
            if (i_cmd.step && (!rd_valid || id_match)) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= ENTRIES'(1);
        end else if (i_cmd.step && id_match) begin
            r_valid[r_idx] <= 1'b0;
        end else if (i_cmd.alloc && r_have_free) begin
            r_valid[r_free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_names[0] <= SRV_KEY;
            r_ids[0]   <= '0;
        end else if (i_cmd.write_id) begin
            r_ids[r_idx] <= r_tid;
        end else if (i_cmd.alloc && r_have_free) begin
            r_names[r_free_idx] <= r_key;
            r_ids[r_free_idx]   <= r_tid;
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.key_zero  = (r_key == '0);
        o_stat.op_reg    = (r_op == OP_REGISTER);
        o_stat.hit       = hit;
        o_stat.last      = (r_idx == LAST_IDX);
        o_stat.have_free = r_have_free;
    end

endmodule

>>> rtl/name_to_id_registry_table.sv
// ----------------------------------------------------------------------------
// name_to_id_registry_table
// Fixed table of name keys and task ids with lookup and register requests.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries i_operation (0 lookup,
// 1 register), i_name_key (bytes packed, first byte lowest) and i_task_id.
// Output channel (o_out_valid / i_out_ready) returns one transaction per
// request: o_success and o_found_id (id on a successful lookup, else zero).
// A request is handled by a scan of one table entry per cycle. An empty
// name finishes at the first scan step; a lookup or register ends the
// scan at the entry it hits; a register without a hit walks all ENTRIES
// entries and then takes an allocation step. Each request is accepted
// first, and its result is moved into the output register at the end.
// o_in_ready is high only while no request is in the scan; the next request
// is taken while a previous result still waits in the output register.
// If the receiver stalls with a result pending, the following result waits
// in the block and o_in_ready stays low until the output register frees.
// Reset empties the output register and leaves only entry 0 valid, holding
// the server's own name with id 0. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module name_to_id_registry_table #(
    parameter int ENTRIES    = nidr_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = nidr_pkg::NAME_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_operation,
    input  logic [nidr_pkg::KEY_W-1:0] i_name_key,
    input  logic [nidr_pkg::ID_W-1:0]  i_task_id,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_success,
    output logic [nidr_pkg::ID_W-1:0]  o_found_id
);
    import nidr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    nidr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nidr_dp #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_name_key  (i_name_key),
        .i_task_id   (i_task_id),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_success   (o_success),
        .o_found_id  (o_found_id)
    );

endmodule

>>> rtl/nidr_chk.sv
// ----------------------------------------------------------------------------
// nidr_chk
// Port-level checks for the registry table, bound to the top level.
// ----------------------------------------------------------------------------
module nidr_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_operation,
    input logic [nidr_pkg::KEY_W-1:0] i_name_key,
    input logic [nidr_pkg::ID_W-1:0]  i_task_id,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_success,
    input logic [nidr_pkg::ID_W-1:0]  o_found_id
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_success) && $stable(o_found_id)))
        else $error("output transaction dropped or changed while stalled");

    // failed requests never report an id
    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_success) |-> (o_found_id == '0))
        else $error("nonzero id on a failed request");

    // one request at a time: the scan closes the input right after accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted during a scan");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind name_to_id_registry_table nidr_chk u_nidr_chk (.*);
